FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: invariant");

// ante at one edge implies cons at the next
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/u8to16_pkg.sv
// ----------------------------------------------------------------------------
// u8to16_pkg
// Types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8to16_pkg;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
   localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0]     SURR_HIGH = 16'hD800;
   localparam logic [15:0]     SURR_LOW  = 16'hDC00;

   localparam logic [7:0] ASCII_HI  = 8'h7F;
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] LEAD4_HI  = 8'hF4;
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] LEAD_E0   = 8'hE0;
   localparam logic [7:0] LEAD_ED   = 8'hED;
   localparam logic [7:0] LEAD_F0   = 8'hF0;
   localparam logic [7:0] LEAD_F4   = 8'hF4;
   localparam logic [7:0] E0_LO     = 8'hA0;
   localparam logic [7:0] ED_HI     = 8'h9F;
   localparam logic [7:0] F0_LO     = 8'h90;
   localparam logic [7:0] F4_HI     = 8'h8F;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        malformed;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        count;
      rsp_type [1:0]     unit;
   } res_pair_type;

endpackage

FILE: rtl/u8to16_in_stage.sv
// ----------------------------------------------------------------------------
// u8to16_in_stage
// Input register: holds one request word until the decoder takes it.
// ----------------------------------------------------------------------------
module u8to16_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  u8to16_pkg::req_type req_data,
   input  logic                take,
   output logic                in_valid,
   output u8to16_pkg::req_type in_word
);

   logic                valid_ff, valid_in;
   u8to16_pkg::req_type word_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         word_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

FILE: rtl/u8to16_decode.sv
// ----------------------------------------------------------------------------
// u8to16_decode
// Sequence state and per-word decode into up to two UTF-16 units.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8to16_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_wdata,
   input  logic                     fire,
   input  u8to16_pkg::req_type      in_word,
   output u8to16_pkg::res_pair_type res
);

   localparam int CP_W = u8to16_pkg::CP_W;

   logic            discard_ff;
   logic [7:0]      lead_ff, lead_in;
   logic [2:0]      exp_ff, exp_in;
   logic [2:0]      seen_ff, seen_in;
   logic [CP_W-1:0] pv_ff, pv_in;

   logic [7:0]      b;
   logic [2:0]      st_len;
   logic [CP_W-1:0] st_val;
   logic            st_emit, st_bad;
   logic [CP_W-1:0] st_cp;
   logic [7:0]      lo, hi;
   logic            ok;
   logic [CP_W-1:0] acc;
   logic [2:0]      seen_inc;

   logic            e0_v, e0_bad, e1_v, e1_bad;
   logic [CP_W-1:0] e0_cp, e1_cp, sc;
   logic            kept0, kept1, supp;
   u8to16_pkg::rsp_type u_a, u_b, u_1;

   assign b = in_word.byte_value;

   // start of a new sequence
   always_comb begin
      st_len  = 3'd0;
      st_val  = '0;
      st_emit = 1'b0;
      st_bad  = 1'b0;
      st_cp   = '0;
      case (b) inside
         [8'h00:u8to16_pkg::ASCII_HI]: begin
            st_emit = 1'b1;
            st_cp   = {{(CP_W-8){1'b0}}, b};
         end
         [u8to16_pkg::LEAD2_LO:u8to16_pkg::LEAD2_HI]: begin
            st_len = 3'd2;
            st_val = {{(CP_W-5){1'b0}}, b[4:0]};
         end
         [u8to16_pkg::LEAD3_LO:u8to16_pkg::LEAD3_HI]: begin
            st_len = 3'd3;
            st_val = {{(CP_W-4){1'b0}}, b[3:0]};
         end
         [u8to16_pkg::LEAD4_LO:u8to16_pkg::LEAD4_HI]: begin
            st_len = 3'd4;
            st_val = {{(CP_W-3){1'b0}}, b[2:0]};
         end
         default: begin
            st_emit = 1'b1;
            st_bad  = 1'b1;
            st_cp   = u8to16_pkg::REPL_CP;
         end
      endcase
   end

   // continuation range check
   always_comb begin
      lo = u8to16_pkg::CONT_LO;
      hi = u8to16_pkg::CONT_HI;
      if (seen_ff == 3'd1) begin
         if (lead_ff == u8to16_pkg::LEAD_E0) lo = u8to16_pkg::E0_LO;
         if (lead_ff == u8to16_pkg::LEAD_ED) hi = u8to16_pkg::ED_HI;
         if (lead_ff == u8to16_pkg::LEAD_F0) lo = u8to16_pkg::F0_LO;
         if (lead_ff == u8to16_pkg::LEAD_F4) hi = u8to16_pkg::F4_HI;
      end
      ok = (b >= lo) && (b <= hi);
   end

   assign acc      = {pv_ff[CP_W-7:0], b[5:0]};
   assign seen_inc = seen_ff + 3'd1;

   always_comb begin
      lead_in = lead_ff;
      exp_in  = exp_ff;
      seen_in = seen_ff;
      pv_in   = pv_ff;
      e0_v    = 1'b0;
      e0_bad  = 1'b0;
      e0_cp   = '0;
      e1_v    = 1'b0;
      e1_bad  = 1'b0;
      e1_cp   = '0;
      if (in_word.opcode == u8to16_pkg::OP_FLUSH) begin
         if (exp_ff != 3'd0) begin
            lead_in = '0;
            exp_in  = '0;
            seen_in = '0;
            pv_in   = '0;
            e0_v    = 1'b1;
            e0_bad  = 1'b1;
            e0_cp   = u8to16_pkg::REPL_CP;
         end
      end else if (exp_ff == 3'd0) begin
         if (st_len != 3'd0) begin
            lead_in = b;
            exp_in  = st_len;
            seen_in = 3'd1;
            pv_in   = st_val;
         end
         e0_v   = st_emit;
         e0_bad = st_bad;
         e0_cp  = st_cp;
      end else if (ok) begin
         if (seen_inc >= exp_ff) begin
            lead_in = '0;
            exp_in  = '0;
            seen_in = '0;
            pv_in   = '0;
            e0_v    = 1'b1;
            e0_cp   = acc;
         end else begin
            pv_in   = acc;
            seen_in = seen_inc;
         end
      end else begin
         // bad continuation: replace the prefix, then restart on this byte
         lead_in = '0;
         exp_in  = '0;
         seen_in = '0;
         pv_in   = '0;
         if (st_len != 3'd0) begin
            lead_in = b;
            exp_in  = st_len;
            seen_in = 3'd1;
            pv_in   = st_val;
         end
         e0_v   = 1'b1;
         e0_bad = 1'b1;
         e0_cp  = u8to16_pkg::REPL_CP;
         e1_v   = st_emit;
         e1_bad = st_bad;
         e1_cp  = st_cp;
      end
   end

   // unit expansion and discard filter
   assign kept0 = e0_v && !(discard_ff && (e0_cp == u8to16_pkg::REPL_CP));
   assign kept1 = e1_v && !(discard_ff && (e1_cp == u8to16_pkg::REPL_CP));
   assign supp  = e0_cp >= u8to16_pkg::SUPP_BASE;
   assign sc    = e0_cp - u8to16_pkg::SUPP_BASE;

   always_comb begin
      u_a.code_unit   = supp ? (u8to16_pkg::SURR_HIGH | {6'b0, sc[19:10]}) : e0_cp[15:0];
      u_a.malformed   = e0_bad;
      u_a.last_of_run = 1'b0;
      u_b.code_unit   = u8to16_pkg::SURR_LOW | {6'b0, sc[9:0]};
      u_b.malformed   = e0_bad;
      u_b.last_of_run = 1'b1;
      u_1.code_unit   = e1_cp[15:0];
      u_1.malformed   = e1_bad;
      u_1.last_of_run = 1'b1;

      res.count = 2'd0;
      res.unit  = {u_b, u_a};
      if (kept0 && supp) begin
         res.count   = 2'd2;
         res.unit[0] = u_a;
         res.unit[1] = u_b;
      end else if (kept0 && kept1) begin
         res.count   = 2'd2;
         res.unit[0] = u_a;
         res.unit[1] = u_1;
      end else if (kept0) begin
         res.count                = 2'd1;
         res.unit[0]              = u_a;
         res.unit[0].last_of_run  = 1'b1;
      end else if (kept1) begin
         res.count   = 2'd1;
         res.unit[0] = u_1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff <= 1'b0;
         lead_ff    <= '0;
         exp_ff     <= '0;
         seen_ff    <= '0;
         pv_ff      <= '0;
      end else begin
         if (csr_we) begin
            discard_ff <= csr_wdata;
         end
         if (fire) begin
            lead_ff <= lead_in;
            exp_ff  <= exp_in;
            seen_ff <= seen_in;
            pv_ff   <= pv_in;
         end
      end
   end

   `ASSERT_ALWAYS(a_idle_no_seen, (exp_ff != 3'd0) || (seen_ff == 3'd0))
   `ASSERT_ALWAYS(a_seen_below_len, (exp_ff == 3'd0) || (seen_ff < exp_ff))

endmodule

FILE: rtl/u8to16_out_reg.sv
// ----------------------------------------------------------------------------
// u8to16_out_reg
// Two-slot result register, drained one word per response handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8to16_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  u8to16_pkg::res_pair_type res,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output u8to16_pkg::rsp_type      rsp_data
);

   logic [1:0]                count_ff, count_in;
   u8to16_pkg::rsp_type [1:0] slot_ff;

   assign room = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = res.count;
      end else if (rsp_ready && (count_ff != 2'd0)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (load) begin
         slot_ff <= res.unit;
      end else if (rsp_ready && (count_ff == 2'd2)) begin
         slot_ff[0] <= slot_ff[1];
      end
   end

   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = slot_ff[0];

   `ASSERT_ALWAYS(a_count_range, count_ff != 2'd3)
   `ASSERT_ALWAYS(a_pair_last, (count_ff != 2'd2) || (!slot_ff[0].last_of_run && slot_ff[1].last_of_run))
   `ASSERT_NEXT(a_pair_drain, (count_ff == 2'd2) && rsp_ready, count_ff == 2'd1)

endmodule

FILE: rtl/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, strict validation.
// ----------------------------------------------------------------------------
// One request word (a byte or a flush) is taken per cycle while the response
// side takes a word every cycle. A word is held in an input register, decoded
// against the pending-sequence state and written to a two-slot result
// register, which presents it as the response. Each response word carries
// one code unit; a word that yields two units (a surrogate pair, or a
// replacement followed by the restarted byte's unit) fills both slots of the
// result register and is drained one unit per response handshake, which sets
// the rate in that case: one unit out per cycle, otherwise one request word
// per cycle.
module utf8_to_utf16_transcoder_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  u8to16_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output u8to16_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_wdata
);

   logic                     in_valid;
   u8to16_pkg::req_type      in_word;
   logic                     room;
   logic                     fire;
   u8to16_pkg::res_pair_type res;

   assign fire = in_valid && room;

   u8to16_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (fire),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   u8to16_decode u_dec (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .in_word   (in_word),
      .res       (res)
   );

   u8to16_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .res       (res),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UTF-16 transcoder. Byte and flush
// words go in under random gaps, expected code units are computed by a local
// decoder model at accept time, and every response word is compared in order.
// Both replacement modes are run over directed and random streams.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STIM_TIMEOUT = 5_000_000;
   localparam int DRAIN_CYCLES = 20;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   u8to16_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   u8to16_pkg::rsp_type rsp_data;
   logic                csr_we;
   logic                csr_wdata;

   utf8_to_utf16_transcoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder model state
   logic        discard_mode = 1'b0;
   logic [7:0]  seq_lead = '0;
   logic [2:0]  seq_len = '0;
   logic [2:0]  seq_seen = '0;
   logic [20:0] seq_bits = '0;

   u8to16_pkg::rsp_type units_of_word[$];
   u8to16_pkg::rsp_type utf16_expected[$];
   int      mismatch_count = 0;
   int      words_sent = 0;
   bit      idle_on = 1'b1;
   logic [7:0] enc_bytes [0:3];

   function automatic logic [7:0] second_lo(logic [7:0] lead);
      if (lead == u8to16_pkg::LEAD_E0) return u8to16_pkg::E0_LO;
      if (lead == u8to16_pkg::LEAD_F0) return u8to16_pkg::F0_LO;
      return u8to16_pkg::CONT_LO;
   endfunction

   function automatic logic [7:0] second_hi(logic [7:0] lead);
      if (lead == u8to16_pkg::LEAD_ED) return u8to16_pkg::ED_HI;
      if (lead == u8to16_pkg::LEAD_F4) return u8to16_pkg::F4_HI;
      return u8to16_pkg::CONT_HI;
   endfunction

   function automatic void put_code_point(logic [20:0] cp, logic bad);
      logic [20:0]         off;
      u8to16_pkg::rsp_type u;
      if (discard_mode && cp == u8to16_pkg::REPL_CP) return;
      u.malformed   = bad;
      u.last_of_run = 1'b0;
      if (cp < u8to16_pkg::SUPP_BASE) begin
         u.code_unit = cp[15:0];
         units_of_word.insert(units_of_word.size(), u);
      end else begin
         off = cp - u8to16_pkg::SUPP_BASE;
         u.code_unit = u8to16_pkg::SURR_HIGH + {6'd0, off[19:10]};
         units_of_word.insert(units_of_word.size(), u);
         u.code_unit = u8to16_pkg::SURR_LOW + {6'd0, off[9:0]};
         units_of_word.insert(units_of_word.size(), u);
      end
   endfunction

   function automatic void clear_sequence();
      seq_lead = '0;
      seq_len  = '0;
      seq_seen = '0;
      seq_bits = '0;
   endfunction

   function automatic void open_sequence(logic [7:0] b);
      if (b <= u8to16_pkg::ASCII_HI) begin
         put_code_point({13'd0, b}, 1'b0);
         return;
      end
      if (b >= u8to16_pkg::LEAD2_LO && b <= u8to16_pkg::LEAD2_HI) begin
         seq_len  = 3'd2;
         seq_bits = {16'd0, b[4:0]};
      end else if (b >= u8to16_pkg::LEAD3_LO && b <= u8to16_pkg::LEAD3_HI) begin
         seq_len  = 3'd3;
         seq_bits = {17'd0, b[3:0]};
      end else if (b >= u8to16_pkg::LEAD4_LO && b <= u8to16_pkg::LEAD4_HI) begin
         seq_len  = 3'd4;
         seq_bits = {18'd0, b[2:0]};
      end else begin
         put_code_point(u8to16_pkg::REPL_CP, 1'b1);
         return;
      end
      seq_lead = b;
      seq_seen = 3'd1;
   endfunction

   function automatic void decode_word(u8to16_pkg::req_type w);
      logic                ok;
      logic [20:0]         cp;
      u8to16_pkg::rsp_type u;
      units_of_word.delete();
      if (w.opcode == u8to16_pkg::OP_FLUSH) begin
         if (seq_len != 0) begin
            clear_sequence();
            put_code_point(u8to16_pkg::REPL_CP, 1'b1);
         end
      end else if (seq_len == 0) begin
         open_sequence(w.byte_value);
      end else begin
         if (seq_seen == 3'd1)
            ok = w.byte_value >= second_lo(seq_lead) && w.byte_value <= second_hi(seq_lead);
         else
            ok = w.byte_value >= u8to16_pkg::CONT_LO && w.byte_value <= u8to16_pkg::CONT_HI;
         if (ok) begin
            seq_bits = {seq_bits[14:0], w.byte_value[5:0]};
            seq_seen = seq_seen + 3'd1;
            if (seq_seen >= seq_len) begin
               cp = seq_bits;
               clear_sequence();
               put_code_point(cp, 1'b0);
            end
         end else begin
            clear_sequence();
            put_code_point(u8to16_pkg::REPL_CP, 1'b1);
            open_sequence(w.byte_value);
         end
      end
      if (units_of_word.size() > 0) begin
         u = units_of_word[units_of_word.size()-1];
         u.last_of_run = 1'b1;
         units_of_word[units_of_word.size()-1] = u;
      end
      foreach (units_of_word[i]) utf16_expected.insert(utf16_expected.size(), units_of_word[i]);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(logic op, logic [7:0] b);
      int                  gap;
      u8to16_pkg::req_type w;
      w.opcode     = op;
      w.byte_value = b;
      gap = idle_on ? int'($urandom_range(0, 6)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic set_discard(logic v);
      req_valid <= 1'b0;
      wait (utf16_expected.size() == 0);
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we       <= 1'b0;
      discard_mode = v;
   endtask

   task automatic test_directed_cases();
      logic [7:0] dir_bytes [0:25] = '{
         8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBD,
         8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF,
         8'hE0, 8'h80, 8'hC2, 8'h41, 8'hE1, 8'h80};
      foreach (dir_bytes[i]) send_word(u8to16_pkg::OP_DATA, dir_bytes[i]);
      send_word(u8to16_pkg::OP_FLUSH, 8'hFF);
      send_word(u8to16_pkg::OP_FLUSH, 8'h00);
   endtask

   task automatic build_char(int len);
      int r;
      case (len)
         1: enc_bytes[0] = 8'($urandom_range(0, u8to16_pkg::ASCII_HI));
         2: enc_bytes[0] = 8'($urandom_range(u8to16_pkg::LEAD2_LO, u8to16_pkg::LEAD2_HI));
         3: enc_bytes[0] = 8'($urandom_range(u8to16_pkg::LEAD3_LO, u8to16_pkg::LEAD3_HI));
         default: enc_bytes[0] = 8'($urandom_range(u8to16_pkg::LEAD4_LO, u8to16_pkg::LEAD4_HI));
      endcase
      r = int'($urandom_range(0, 3));
      if (r == 0)
         enc_bytes[1] = second_lo(enc_bytes[0]);
      else if (r == 1)
         enc_bytes[1] = second_hi(enc_bytes[0]);
      else
         enc_bytes[1] = 8'($urandom_range(second_lo(enc_bytes[0]), second_hi(enc_bytes[0])));
      enc_bytes[2] = 8'($urandom_range(u8to16_pkg::CONT_LO, u8to16_pkg::CONT_HI));
      enc_bytes[3] = 8'($urandom_range(u8to16_pkg::CONT_LO, u8to16_pkg::CONT_HI));
   endtask

   task automatic test_random_streams(int n_words);
      int start, kind, len, cut, r;
      start = words_sent;
      while (words_sent - start < n_words) begin
         if ($urandom_range(0, 99) == 0) idle_on = $urandom_range(0, 3) != 0;
         kind = int'($urandom_range(0, 99));
         if (kind < 75) begin
            len = int'($urandom_range(1, 4));
            build_char(len);
            cut = (kind < 60 || len == 1) ? len : int'($urandom_range(1, len - 1));
            for (int i = 0; i < cut; i++) send_word(u8to16_pkg::OP_DATA, enc_bytes[i]);
            if (cut < len) begin
               r = int'($urandom_range(0, 3));
               if (r == 0)
                  send_word(u8to16_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
               else if (r == 1)
                  send_word(u8to16_pkg::OP_DATA, 8'($urandom_range(0, 255)));
               else if (cut == 1)
                  send_word(u8to16_pkg::OP_DATA,
                            r == 2 ? second_lo(enc_bytes[0]) - 8'd1
                                   : second_hi(enc_bytes[0]) + 8'd1);
               else
                  send_word(u8to16_pkg::OP_DATA,
                            r == 2 ? u8to16_pkg::CONT_LO - 8'd1 : u8to16_pkg::CONT_HI + 8'd1);
            end
         end else if (kind < 90) begin
            send_word(u8to16_pkg::OP_DATA, 8'($urandom_range(0, 255)));
         end else begin
            send_word(u8to16_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
         end
      end
      idle_on = 1'b1;
   endtask

   // response side: random stalls, in-order compare
   initial begin : rsp_side
      int                  stall;
      u8to16_pkg::rsp_type got;
      u8to16_pkg::rsp_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_on ? int'($urandom_range(0, 6)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = rsp_data;
         if (utf16_expected.size() == 0) begin
            $error("unexpected response word: code_unit %h", got.code_unit);
            mismatch_count++;
         end else begin
            want = utf16_expected.pop_front();
            if (got.code_unit !== want.code_unit) begin
               $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
               mismatch_count++;
            end
            if (got.malformed !== want.malformed) begin
               $error("malformed: expected %b, got %b", want.malformed, got.malformed);
               mismatch_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #STIM_TIMEOUT;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      set_discard(1'b1);
      test_directed_cases();
      test_random_streams(500);
      set_discard(1'b0);
      test_random_streams(700);
      set_discard(1'b1);
      test_random_streams(300);
      set_discard(1'b0);
      test_random_streams(300);

      req_valid <= 1'b0;
      wait (utf16_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
